// File: sv/vrdt_pkg.sv
// Shared types, constants and helpers for the voxel ray traversal block.
// No dependencies; compiled before the interfaces and modules.
package vrdt_pkg;
    localparam int unsigned CoordW   = 5;
    localparam int unsigned GridDim  = 32;
    localparam int unsigned CellW    = 12;   // signed cell coordinate while walking
    localparam int unsigned AddrW    = 15;
    localparam int unsigned ColourW  = 24;
    localparam int unsigned StepW    = 10;
    localparam int unsigned ExtW     = 6;
    localparam int unsigned TW       = 32;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 10;
    localparam logic [StepW-1:0] StepLimitMax = 10'd1023;
    localparam logic [TW-1:0] TInf = 32'hFFFF_FFFF;

    localparam logic [CfgIdxW-1:0] CfgMaxSteps = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgExtentX  = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgExtentY  = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgExtentZ  = 2'd3;

    localparam logic OpWrite = 1'b0;
    localparam logic OpTrace = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [CoordW-1:0]   cell_x;
        logic [CoordW-1:0]   cell_y;
        logic [CoordW-1:0]   cell_z;
        logic                solid_in;
        logic [ColourW-1:0]  colour_in;
        logic signed [15:0]  origin_x;
        logic signed [15:0]  origin_y;
        logic signed [15:0]  origin_z;
        logic signed [15:0]  dir_x;
        logic signed [15:0]  dir_y;
        logic signed [15:0]  dir_z;
    } t_in_word;

    typedef struct packed {
        logic               hit;
        logic [CoordW-1:0]  hit_x;
        logic [CoordW-1:0]  hit_y;
        logic [CoordW-1:0]  hit_z;
        logic [ColourW-1:0] colour_out;
    } t_out_word;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the input word, start reciprocal divide
        logic div_step;  // one restoring-divide bit on every axis
        logic tmax_calc; // compute first boundary t from delta
        logic clr_gen;   // clear sweep advance
        logic write;     // store one voxel
        logic probe;     // read current cell
        logic advance;   // take one DDA step
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic div_done;
        logic clr_done;
        logic in_grid;
        logic solid;     // registered read of the probed cell
    } t_dp_sts;

    function automatic logic [ExtW-1:0] clamp_ext(input logic [ExtW-1:0] e);
        return (e > ExtW'(GridDim)) ? ExtW'(GridDim) : e;
    endfunction

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                              input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? TInf : s[TW-1:0];
    endfunction
endpackage

// File: sv/vrdt_stream_if.sv
// Valid/ready stream interface carrying one payload word.
// No dependencies; the payload type is a parameter.
interface vrdt_stream_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/vrdt_datapath.sv
// Datapath: voxel memories, per-axis reciprocal divider, DDA registers.
// Depends on vrdt_pkg.
module vrdt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vrdt_pkg::t_in_word            i_word,
    input  vrdt_pkg::t_dp_cmd             i_cmd,
    input  logic [vrdt_pkg::ExtW-1:0]     i_ext_x,
    input  logic [vrdt_pkg::ExtW-1:0]     i_ext_y,
    input  logic [vrdt_pkg::ExtW-1:0]     i_ext_z,
    output vrdt_pkg::t_dp_sts             o_sts,
    output vrdt_pkg::t_out_word           o_hit_word
);
    localparam int unsigned TW = vrdt_pkg::TW;
    localparam int unsigned CW = vrdt_pkg::CellW;
    localparam int unsigned AW = vrdt_pkg::AddrW;

    logic                        r_solid [2**AW];
    logic [vrdt_pkg::ColourW-1:0] r_colour [2**AW];
    logic                        r_rd_solid;
    logic [vrdt_pkg::ColourW-1:0] r_rd_colour;
    logic [AW:0]                 r_clr_addr;
    logic [4:0]                  r_div_cnt;
    logic                        r_div_done;

    logic signed [CW-1:0] r_m [3];
    logic                 r_neg [3];
    logic [15:0]          r_mag [3];
    logic [7:0]           r_frac [3];
    logic [TW-1:0]        r_q [3];
    logic [16:0]          r_rem [3];
    logic [TW-1:0]        r_t [3];
    logic [TW-1:0]        r_d [3];
    logic [vrdt_pkg::CoordW-1:0] r_px, r_py, r_pz;

    logic signed [15:0] org [3];
    logic signed [15:0] dir [3];
    logic [vrdt_pkg::ExtW-1:0] ext [3];
    logic in_b;
    logic [AW-1:0] probe_addr;
    logic [AW-1:0] wr_addr;
    logic sel_x, sel_y;

    assign org[0] = i_word.origin_x; assign dir[0] = i_word.dir_x;
    assign org[1] = i_word.origin_y; assign dir[1] = i_word.dir_y;
    assign org[2] = i_word.origin_z; assign dir[2] = i_word.dir_z;
    assign ext[0] = vrdt_pkg::clamp_ext(i_ext_x);
    assign ext[1] = vrdt_pkg::clamp_ext(i_ext_y);
    assign ext[2] = vrdt_pkg::clamp_ext(i_ext_z);

    always_comb begin
        in_b = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (r_m[a] < 0 || r_m[a] >= $signed({{(CW-vrdt_pkg::ExtW){1'b0}}, ext[a]}))
                in_b = 1'b0;
        end
        probe_addr = {r_m[2][4:0], r_m[1][4:0], r_m[0][4:0]};
        wr_addr = {i_word.cell_z, i_word.cell_y, i_word.cell_x};
        sel_x = (r_t[0] < r_t[1]) && (r_t[0] < r_t[2]);
        sel_y = !sel_x && (r_t[1] < r_t[2]);
    end

    // Solid store: written by voxel writes or by the clear sweep.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_gen) begin
            r_solid[r_clr_addr[AW-1:0]] <= 1'b0;
        end else if (i_cmd.write) begin
            r_solid[wr_addr] <= i_word.solid_in;
        end
        if (i_cmd.probe) begin
            r_rd_solid <= r_solid[probe_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_colour[wr_addr] <= i_word.colour_in;
        end
        if (i_cmd.probe) begin
            r_rd_colour <= r_colour[probe_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_div_cnt  <= '0;
            r_div_done <= 1'b0;
        end else begin
            if (i_cmd.clr_gen && !r_clr_addr[AW]) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load) begin
                r_div_cnt  <= '0;
                r_div_done <= 1'b0;
            end else if (i_cmd.div_step) begin
                r_div_cnt  <= r_div_cnt + 1'b1;
                r_div_done <= (r_div_cnt == 5'd30);
            end
        end
    end

    // Per-axis state: 31-bit restoring divide of 2^30 by |dir|, then DDA.
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            logic [16:0] trial;
            logic [TW+8-1:0] prod;
            trial = {r_rem[a][15:0], (r_div_cnt == 5'd0)};
            prod  = '0;
            if (i_cmd.load) begin
                r_m[a]    <= CW'(org[a] >>> 8);
                r_frac[a] <= org[a][7:0];
                r_neg[a]  <= dir[a][15];
                r_mag[a]  <= dir[a][15] ? 16'(-dir[a]) : dir[a];
                r_q[a]    <= '0;
                r_rem[a]  <= '0;
            end else if (i_cmd.div_step) begin
                if (trial >= {1'b0, r_mag[a]}) begin
                    r_rem[a] <= trial - {1'b0, r_mag[a]};
                    r_q[a]   <= {r_q[a][TW-2:0], 1'b1};
                end else begin
                    r_rem[a] <= trial;
                    r_q[a]   <= {r_q[a][TW-2:0], 1'b0};
                end
            end else if (i_cmd.tmax_calc) begin
                if (r_mag[a] == '0) begin
                    r_d[a] <= vrdt_pkg::TInf;
                    r_t[a] <= vrdt_pkg::TInf;
                end else begin
                    prod = (r_neg[a] ? {1'b0, r_frac[a]} : (9'd256 - {1'b0, r_frac[a]}))
                           * r_q[a][30:0];
                    r_d[a] <= r_q[a];
                    r_t[a] <= prod[TW+8-1:8];
                end
            end else if (i_cmd.advance) begin
                if ((a == 0 && sel_x) || (a == 1 && sel_y) || (a == 2 && !sel_x && !sel_y))
                begin
                    r_m[a] <= r_neg[a] ? r_m[a] - 1'b1 : r_m[a] + 1'b1;
                    r_t[a] <= vrdt_pkg::sat_add(r_t[a], r_d[a]);
                end
            end
        end
        if (i_cmd.probe) begin
            r_px <= r_m[0][4:0]; r_py <= r_m[1][4:0]; r_pz <= r_m[2][4:0];
        end
    end

    assign o_sts.div_done  = r_div_done;
    assign o_sts.clr_done  = r_clr_addr[AW];
    assign o_sts.in_grid   = in_b;
    assign o_sts.solid     = r_rd_solid;
    assign o_hit_word.hit        = 1'b1;
    assign o_hit_word.hit_x      = r_px;
    assign o_hit_word.hit_y      = r_py;
    assign o_hit_word.hit_z      = r_pz;
    assign o_hit_word.colour_out = r_rd_colour;
endmodule

// File: sv/vrdt_ctrl.sv
// Controller: sequences clear sweep, writes, divide setup and DDA stepping.
// Depends on vrdt_pkg.
module vrdt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_op,
    output logic                          o_in_ready,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_miss,
    input  logic [vrdt_pkg::StepW-1:0]    i_step_limit,
    input  vrdt_pkg::t_dp_sts             i_sts,
    output vrdt_pkg::t_dp_cmd             o_cmd
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DIV, S_TMAX, S_STEP, S_CHECK, S_OUT
    } t_state;

    t_state r_state;
    logic [vrdt_pkg::StepW-1:0] r_cnt;
    logic r_miss;
    logic accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_OUT);
    assign o_miss      = r_miss;

    always_comb begin
        o_cmd = '0;
        o_cmd.clr_gen   = (r_state == S_CLEAR);
        o_cmd.write     = accept && (i_in_op == vrdt_pkg::OpWrite);
        o_cmd.load      = accept && (i_in_op == vrdt_pkg::OpTrace);
        o_cmd.div_step  = (r_state == S_DIV) && !i_sts.div_done;
        o_cmd.tmax_calc = (r_state == S_TMAX);
        o_cmd.probe     = (r_state == S_STEP) && (r_cnt != '0) && i_sts.in_grid;
        o_cmd.advance   = (r_state == S_STEP) && (r_cnt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_miss  <= 1'b1;
        end else begin
            unique case (r_state)
                S_CLEAR: if (i_sts.clr_done) r_state <= S_IDLE;
                S_IDLE: begin
                    if (o_cmd.load) r_state <= S_DIV;
                end
                S_DIV: if (i_sts.div_done) r_state <= S_TMAX;
                S_TMAX: begin
                    r_cnt   <= (i_step_limit > vrdt_pkg::StepLimitMax)
                               ? vrdt_pkg::StepLimitMax : i_step_limit;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (r_cnt == '0) begin
                        r_miss  <= 1'b1;
                        r_state <= S_OUT;
                    end else if (i_sts.in_grid) begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_CHECK;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_CHECK: begin
                    if (i_sts.solid) begin
                        r_miss  <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: sv/voxel_ray_dda_traversal.sv
// Top level of the voxel ray traversal block: config registers, controller,
// datapath. Depends on vrdt_pkg, vrdt_stream_if, vrdt_ctrl, vrdt_datapath.
//
// Holds a 32x32x32 voxel grid (solid bit plus 24-bit colour) and walks rays
// through it with a 3D DDA. After reset the block sweeps the solid store clear,
// accepting no word, before it takes its first word. A write word is stored as
// it is accepted, and the block stays ready. A trace word is accepted, then runs
// a bit-serial reciprocal divide (31 quotient bits, one per cycle on all three
// axes), then first-boundary setup, then DDA steps up to the step limit; a step
// inside the grid also passes through a check state, since the memory read is
// registered before the solid test. On a miss the step state sees the spent
// limit before the result is offered. The result word is then offered and
// holds until taken. Each trace gives one result word; a miss reads all
// zeros. Configuration may be written any time the block is idle.
module voxel_ray_dda_traversal (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    vrdt_stream_if.sink                           in_if,
    vrdt_stream_if.source                         out_if,
    input  logic                                  i_cfg_we,
    input  logic [vrdt_pkg::CfgIdxW-1:0]          i_cfg_idx,
    input  logic [vrdt_pkg::CfgDataW-1:0]         i_cfg_data
);
    logic [vrdt_pkg::StepW-1:0] r_step_limit;
    logic [vrdt_pkg::ExtW-1:0]  r_ext_x, r_ext_y, r_ext_z;
    vrdt_pkg::t_dp_cmd   cmd;
    vrdt_pkg::t_dp_sts   sts;
    vrdt_pkg::t_out_word hit_word;
    logic miss;

    // Config registers; all four indexes are decoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= 10'd200;
            r_ext_x <= 6'd32;
            r_ext_y <= 6'd32;
            r_ext_z <= 6'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vrdt_pkg::CfgMaxSteps: r_step_limit <= i_cfg_data;
                vrdt_pkg::CfgExtentX:  r_ext_x <= i_cfg_data[vrdt_pkg::ExtW-1:0];
                vrdt_pkg::CfgExtentY:  r_ext_y <= i_cfg_data[vrdt_pkg::ExtW-1:0];
                vrdt_pkg::CfgExtentZ:  r_ext_z <= i_cfg_data[vrdt_pkg::ExtW-1:0];
                default: ;
            endcase
        end
    end

    vrdt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_if.valid),
        .i_in_op      (in_if.data.opcode),
        .o_in_ready   (in_if.ready),
        .i_out_ready  (out_if.ready),
        .o_out_valid  (out_if.valid),
        .o_miss       (miss),
        .i_step_limit (r_step_limit),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    vrdt_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (in_if.data),
        .i_cmd      (cmd),
        .i_ext_x    (r_ext_x),
        .i_ext_y    (r_ext_y),
        .i_ext_z    (r_ext_z),
        .o_sts      (sts),
        .o_hit_word (hit_word)
    );

    // A miss shows all zeros.
    assign out_if.data = miss ? '0 : hit_word;
endmodule

// File: sv/vrdt_checker.sv
// Port-level checker for the voxel ray traversal block, bound to the top.
// Depends on vrdt_pkg.
module vrdt_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   in_op,
    input logic                   out_valid,
    input logic                   out_ready,
    input vrdt_pkg::t_out_word    out_data
);
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.hit |-> out_data == '0)
        else $error("miss word not zero");
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_trace_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_op |=> !in_ready)
        else $error("ready after trace accept");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
endmodule

bind voxel_ray_dda_traversal vrdt_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_op     (in_if.data.opcode),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_if.data)
);

// File: tb/tb_voxel_ray_dda_traversal.sv
// Self-checking testbench for the voxel ray traversal block.
// Depends on vrdt_pkg, vrdt_stream_if and the voxel_ray_dda_traversal RTL.
// Directed table first, then random writes and rays over several register settings.
`timescale 1ns / 100ps

module tb_voxel_ray_dda_traversal;
    localparam int IdlePct  = 27;
    localparam int DirRows  = 19;
    localparam int Phases   = 7;
    localparam int Settle   = 40;      // cycles to let a trailing write drain
    localparam int HoldLen  = 1500;    // long receiver hold-off
    localparam int Half     = 128;     // half a cell in Q8.8
    localparam int CellSize = 256;     // one cell in Q8.8
    localparam int Unit     = 16384;   // 1.0 in Q2.14
    localparam int Dim      = int'(vrdt_pkg::GridDim);

    typedef struct {
        vrdt_pkg::t_in_word  word;
        bit                  typed;     // expected result written in the row
        vrdt_pkg::t_out_word res;
    } t_dir_row;

    typedef struct {
        logic [vrdt_pkg::StepW-1:0] steps;
        logic [vrdt_pkg::ExtW-1:0]  ex, ey, ez;
        int                         items;
    } t_phase;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [vrdt_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [vrdt_pkg::CfgDataW-1:0] i_cfg_data;

    vrdt_stream_if #(.T(vrdt_pkg::t_in_word))  in_if  (i_clk);
    vrdt_stream_if #(.T(vrdt_pkg::t_out_word)) out_if (i_clk);

    voxel_ray_dda_traversal uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_if      (in_if),
        .out_if     (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the block: grid contents and register settings.
    bit                         grid_solid [Dim*Dim*Dim];
    logic [23:0]                grid_colour[Dim*Dim*Dim];
    logic [vrdt_pkg::StepW-1:0] shadow_steps;
    logic [vrdt_pkg::ExtW-1:0]  shadow_ext[3];

    vrdt_pkg::t_out_word ray_result_q[$];
    int        fail_count;
    int        words_sent;
    int        results_seen;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Start cell, step sign, reciprocal delta and first boundary t for one axis.
    function automatic void axis_init(input logic signed [15:0] org,
                                      input logic signed [15:0] dir,
                                      output int org_cell, output int stp,
                                      output logic [31:0] dlt, output logic [31:0] tnext);
        int             d;
        longint unsigned mag;
        longint unsigned frac;
        longint unsigned t;
        org_cell = int'(org) >>> 8;
        frac = longint'(org[7:0]);
        d    = int'(dir);
        stp  = (d < 0) ? -1 : 1;
        mag  = (d < 0) ? longint'(-d) : longint'(d);
        if (mag == 0) begin
            dlt   = 32'hFFFF_FFFF;
            tnext = 32'hFFFF_FFFF;
            return;
        end
        dlt = 32'((64'd1 << 30) / mag);
        if (d > 0) t = ((256 - frac) * longint'(dlt)) >> 8;
        else       t = (frac * longint'(dlt)) >> 8;
        tnext = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    function automatic int ext_used(input logic [vrdt_pkg::ExtW-1:0] e);
        return (int'(e) > Dim) ? Dim : int'(e);
    endfunction

    // Walk one ray through the shadow grid.
    function automatic vrdt_pkg::t_out_word trace_ray(input vrdt_pkg::t_in_word w);
        int                  m[3], s[3], ext[3], idx;
        logic [31:0]         dl[3], tn[3];
        vrdt_pkg::t_out_word r;
        bit                  inb;
        r = '0;
        axis_init(w.origin_x, w.dir_x, m[0], s[0], dl[0], tn[0]);
        axis_init(w.origin_y, w.dir_y, m[1], s[1], dl[1], tn[1]);
        axis_init(w.origin_z, w.dir_z, m[2], s[2], dl[2], tn[2]);
        for (int a = 0; a < 3; a++) ext[a] = ext_used(shadow_ext[a]);
        for (int n = 0; n < int'(shadow_steps); n++) begin
            inb = 1'b1;
            for (int a = 0; a < 3; a++)
                if (m[a] < 0 || m[a] >= ext[a]) inb = 1'b0;
            if (inb) begin
                idx = m[0] + Dim * (m[1] + Dim * m[2]);
                if (grid_solid[idx]) begin
                    r.hit        = 1'b1;
                    r.hit_x      = m[0][4:0];
                    r.hit_y      = m[1][4:0];
                    r.hit_z      = m[2][4:0];
                    r.colour_out = grid_colour[idx];
                    return r;
                end
            end
            // Ties never go to x; a tie between y and z goes to z.
            if (tn[0] < tn[1] && tn[0] < tn[2]) begin
                m[0] += s[0];
                tn[0] = add_sat(tn[0], dl[0]);
            end else if (tn[1] < tn[2]) begin
                m[1] += s[1];
                tn[1] = add_sat(tn[1], dl[1]);
            end else begin
                m[2] += s[2];
                tn[2] = add_sat(tn[2], dl[2]);
            end
        end
        return r;
    endfunction

    function automatic vrdt_pkg::t_in_word wr(input int x, input int y, input int z,
                                              input bit sol, input logic [23:0] col);
        vrdt_pkg::t_in_word w;
        w           = '0;
        w.opcode    = vrdt_pkg::OpWrite;
        w.cell_x    = x[4:0];
        w.cell_y    = y[4:0];
        w.cell_z    = z[4:0];
        w.solid_in  = sol;
        w.colour_in = col;
        return w;
    endfunction

    function automatic vrdt_pkg::t_in_word tr(input int ox, input int oy, input int oz,
                                              input int dx, input int dy, input int dz);
        vrdt_pkg::t_in_word w;
        w          = '0;
        w.opcode   = vrdt_pkg::OpTrace;
        w.origin_x = ox[15:0];
        w.origin_y = oy[15:0];
        w.origin_z = oz[15:0];
        w.dir_x    = dx[15:0];
        w.dir_y    = dy[15:0];
        w.dir_z    = dz[15:0];
        return w;
    endfunction

    function automatic vrdt_pkg::t_out_word hit_at(input int x, input int y, input int z,
                                                   input logic [23:0] col);
        vrdt_pkg::t_out_word r;
        r.hit        = 1'b1;
        r.hit_x      = x[4:0];
        r.hit_y      = y[4:0];
        r.hit_z      = z[4:0];
        r.colour_out = col;
        return r;
    endfunction

    // Random word: writes cluster in the middle of the grid so rays find solids.
    function automatic vrdt_pkg::t_in_word random_word();
        vrdt_pkg::t_in_word w;
        int                 pick;
        w = vrdt_pkg::t_in_word'({$urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(99) < 50) begin
            w.opcode = vrdt_pkg::OpWrite;
            if ($urandom_range(99) < 70) begin
                w.cell_x = 5'($urandom_range(8, 23));
                w.cell_y = 5'($urandom_range(8, 23));
                w.cell_z = 5'($urandom_range(8, 23));
            end
            w.solid_in = ($urandom_range(99) < 80);
        end else begin
            w.opcode = vrdt_pkg::OpTrace;
            pick = $urandom_range(99);
            if (pick < 80) begin
                w.origin_x = 16'($urandom_range(0, 32 * CellSize - 1));
                w.origin_y = 16'($urandom_range(0, 32 * CellSize - 1));
                w.origin_z = 16'($urandom_range(0, 32 * CellSize - 1));
            end else if (pick < 90) begin
                w.origin_x = 16'(int'($urandom_range(0, 36 * CellSize)) - 2 * CellSize);
                w.origin_y = 16'(int'($urandom_range(0, 36 * CellSize)) - 2 * CellSize);
                w.origin_z = 16'(int'($urandom_range(0, 36 * CellSize)) - 2 * CellSize);
            end
            // Zero some axes now and then.
            if ($urandom_range(99) < 10) w.dir_x = '0;
            if ($urandom_range(99) < 10) w.dir_y = '0;
            if ($urandom_range(99) < 10) w.dir_z = '0;
        end
        return w;
    endfunction

    // Write one register and keep the shadow copy in step.
    task automatic cfg_write(input logic [vrdt_pkg::CfgIdxW-1:0] idx,
                             input logic [vrdt_pkg::CfgDataW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            vrdt_pkg::CfgMaxSteps: shadow_steps  = val[vrdt_pkg::StepW-1:0];
            vrdt_pkg::CfgExtentX:  shadow_ext[0] = val[vrdt_pkg::ExtW-1:0];
            vrdt_pkg::CfgExtentY:  shadow_ext[1] = val[vrdt_pkg::ExtW-1:0];
            vrdt_pkg::CfgExtentZ:  shadow_ext[2] = val[vrdt_pkg::ExtW-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_phase(input t_phase p);
        cfg_write(vrdt_pkg::CfgMaxSteps, vrdt_pkg::CfgDataW'(p.steps));
        cfg_write(vrdt_pkg::CfgExtentX,  vrdt_pkg::CfgDataW'(p.ex));
        cfg_write(vrdt_pkg::CfgExtentY,  vrdt_pkg::CfgDataW'(p.ey));
        cfg_write(vrdt_pkg::CfgExtentZ,  vrdt_pkg::CfgDataW'(p.ez));
        i_cfg_we <= 1'b0;
    endtask

    // Offer one word and hold it until accepted; then update the shadow.
    task automatic send_word(input vrdt_pkg::t_in_word w, input bit typed,
                             input vrdt_pkg::t_out_word res);
        bit quiet;
        int widx;
        quiet = (words_sent >= 700 && words_sent < 900);
        if (!quiet && $urandom_range(99) < IdlePct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (!in_if.ready);
        words_sent++;
        if (w.opcode == vrdt_pkg::OpWrite) begin
            widx = int'(w.cell_x) + Dim * (int'(w.cell_y) + Dim * int'(w.cell_z));
            grid_solid [widx] = w.solid_in;
            grid_colour[widx] = w.colour_in;
        end else begin
            ray_result_q.push_back(typed ? res : trace_ray(w));
        end
    endtask

    // Drop valid and wait for every ray to come back before touching registers.
    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (ray_result_q.size() != 0);
        repeat (Settle) @(posedge i_clk);
    endtask

    // Result side: random stalls, one long hold-off, and a stall-free stretch.
    initial begin : result_side
        int                  hold_left;
        bit                  held;
        vrdt_pkg::t_out_word want;
        vrdt_pkg::t_out_word got;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                got = out_if.data;
                results_seen++;
                if (ray_result_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    fail_count++;
                end else begin
                    want = ray_result_q.pop_front();
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit exp %0d act %0d", $time, want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.hit_x !== want.hit_x) begin
                        $display("%0t: hit_x exp %0d act %0d", $time, want.hit_x, got.hit_x);
                        fail_count++;
                    end
                    if (got.hit_y !== want.hit_y) begin
                        $display("%0t: hit_y exp %0d act %0d", $time, want.hit_y, got.hit_y);
                        fail_count++;
                    end
                    if (got.hit_z !== want.hit_z) begin
                        $display("%0t: hit_z exp %0d act %0d", $time, want.hit_z, got.hit_z);
                        fail_count++;
                    end
                    if (got.colour_out !== want.colour_out) begin
                        $display("%0t: colour exp %06h act %06h", $time,
                                 want.colour_out, got.colour_out);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (!held && results_seen == 120) begin
                held      = 1'b1;
                hold_left = HoldLen;
                out_if.ready <= 1'b0;
            end else if (results_seen >= 300 && results_seen < 450) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(99) >= IdlePct);
            end
        end
    end

    initial begin : stimulus
        t_dir_row rows[DirRows];
        t_phase   plan[Phases];
        int       wait_cycles;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        fail_count   = 0;
        words_sent   = 0;
        results_seen = 0;
        shadow_steps = 10'd200;
        shadow_ext   = '{6'd32, 6'd32, 6'd32};
        foreach (grid_solid[i]) grid_solid[i] = 1'b0;

        rows = '{
            // Empty grid after reset: miss.
            '{tr(Half, Half, Half, Unit, 0, 0), 1, '0},
            '{wr(0, 0, 0, 1, 24'hFFFFFF), 0, '0},
            // Ray starting inside a solid cell hits it at once.
            '{tr(Half, Half, Half, 0, 0, 0), 1, hit_at(0, 0, 0, 24'hFFFFFF)},
            '{wr(31, 31, 31, 1, 24'h000001), 0, '0},
            '{tr(31*CellSize+Half, 31*CellSize+Half, 31*CellSize+Half,
                 -32768, -32768, -32768),
              1, hit_at(31, 31, 31, 24'h000001)},
            // All-zero direction walks +z.
            '{tr(31*CellSize+Half, 31*CellSize+Half, -5*CellSize, 0, 0, 0), 0, '0},
            '{wr(16, 16, 16, 1, 24'h123456), 0, '0},
            '{tr(Half, 16*CellSize+Half, 16*CellSize+Half, Unit, 0, 0), 0, '0},
            '{tr(16*CellSize+Half, Half, 16*CellSize+Half, 0, Unit, 0), 0, '0},
            '{tr(16*CellSize+Half, 16*CellSize+Half, Half, 0, 0, Unit), 0, '0},
            // Extreme origins and directions.
            '{tr(-32768, -32768, -32768, 32767, 32767, 32767), 0, '0},
            '{tr(32767, 32767, 32767, -32768, -32768, -32768), 0, '0},
            // Tiny directions drive t into saturation.
            '{tr(16*CellSize, 16*CellSize, 16*CellSize, 1, -1, 1), 0, '0},
            // Equal t on all axes: tie breaking.
            '{tr(15*CellSize, 15*CellSize, 15*CellSize, Unit, Unit, Unit), 0, '0},
            // Clear a cell, then look at it again.
            '{wr(0, 0, 0, 0, 24'h000000), 0, '0},
            '{tr(Half, Half, Half, 0, 0, 0), 0, '0},
            '{tr(-3*CellSize/2, 16*CellSize+Half, 16*CellSize+Half, -Unit, 5000, 300),
              0, '0},
            '{wr(31, 0, 31, 1, 24'h800000), 0, '0},
            '{tr(31*CellSize+255, 255, 31*CellSize+255, 0, -1, 0), 0, '0}
        };

        plan = '{
            '{10'd200,  6'd32, 6'd32, 6'd32, 600},
            '{10'd0,    6'd32, 6'd32, 6'd32, 60},
            '{10'd1023, 6'd32, 6'd32, 6'd32, 60},
            '{10'd64,   6'd16, 6'd8,  6'd32, 300},
            '{10'd300,  6'd1,  6'd32, 6'd5,  150},
            '{10'd100,  6'd0,  6'd20, 6'd63, 100},
            '{10'd511,  6'd31, 6'd33, 6'd17, 380}
        };

        // Hold reset, then release; the block's clear sweep shows up as a stalled input.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].res);
        drain();

        foreach (plan[p]) begin
            apply_phase(plan[p]);
            repeat (plan[p].items) send_word(random_word(), 1'b0, '0);
            drain();
        end

        // Settle and report.
        wait_cycles = 0;
        while (ray_result_q.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && ray_result_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
